// ----- hdl/bdlp_pkg.sv -----
// Package for the button debouncer with long-press detection.
// Event codes, register indexes, reset values and the result struct.
// No dependencies.
package bdlp_pkg;

  localparam int unsigned TimerWidthDefault = 16;
  localparam int unsigned CfgWidth          = 16;
  localparam int unsigned CfgIndexWidth     = 2;

  localparam logic [CfgIndexWidth-1:0] RegEnable    = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegActiveLow = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegDebounce  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] RegLongPress = 2'd3;

  localparam logic [CfgWidth-1:0] DebounceReset  = 16'd50;
  localparam logic [CfgWidth-1:0] LongPressReset = 16'd1000;

  typedef enum logic [1:0] {
    EvRelax    = 2'd0,
    EvLong     = 2'd1,
    EvLongMask = 2'd2,
    EvClickUp  = 2'd3
  } event_e;

  typedef struct packed {
    logic status_valid;
    logic pressed_now;
    logic long_press_event;
    logic click_up_event;
  } result_t;

endpackage

// ----- hdl/button_debounce_long_press.sv -----
// Button debouncer with long-press and click-up events; one tick per request.
// Each accepted result is registered in the output register, or in the skid stage while that one is held.
// Throughput: one request per cycle; the output register plus a one-entry
// skid stage keep accepting while a result waits, stalling only when both hold.
// Reset: registers return to enable 0, active_low 1, lockout 50, long press 1000;
// counter, debounced level, pending release and event state clear to zero.
// Depends on bdlp_pkg.
module button_debounce_long_press #(
  parameter int unsigned TIMER_WIDTH = bdlp_pkg::TimerWidthDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bdlp_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [bdlp_pkg::CfgWidth-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 pin_level_i,
  input  logic                                 read_status_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 status_valid_o,
  output logic                                 pressed_now_o,
  output logic                                 long_press_event_o,
  output logic                                 click_up_event_o
);

  localparam int unsigned CmpWidth =
    (TIMER_WIDTH > bdlp_pkg::CfgWidth) ? TIMER_WIDTH : bdlp_pkg::CfgWidth;
  localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

  logic                          enable_q, active_low_q;
  logic [bdlp_pkg::CfgWidth-1:0] debounce_q, long_press_q;

  logic [TIMER_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                   pressed_q, pressed_d;
  logic                   pending_q, pending_d;
  bdlp_pkg::event_e       ev_q, ev_d;
  bdlp_pkg::result_t      res_d, out_q, skid_q;
  logic                   out_valid_q, skid_valid_q;
  logic                   sample, in_accept, out_take;

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      active_low_q <= 1'b1;
      debounce_q   <= bdlp_pkg::DebounceReset;
      long_press_q <= bdlp_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bdlp_pkg::RegEnable:    enable_q     <= cfg_data_i[0];
        bdlp_pkg::RegActiveLow: active_low_q <= cfg_data_i[0];
        bdlp_pkg::RegDebounce:  debounce_q   <= cfg_data_i;
        bdlp_pkg::RegLongPress: long_press_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign sample      = pin_level_i ^ active_low_q;
  assign elapsed_inc = (elapsed_q == TimerMax) ? elapsed_q : elapsed_q + 1'b1;

  always_comb begin
    elapsed_d = elapsed_inc;
    pressed_d = pressed_q;
    pending_d = pending_q;
    ev_d      = ev_q;
    res_d     = '0;
    if (enable_q && sample != pressed_q &&
        CmpWidth'(elapsed_inc) >= CmpWidth'(debounce_q)) begin
      pressed_d = sample;
      elapsed_d = '0;
      if (!sample) begin
        pending_d = 1'b1;
      end
    end
    if (read_status_i) begin
      if (ev_d != bdlp_pkg::EvLong && ev_d != bdlp_pkg::EvLongMask &&
          pressed_d && CmpWidth'(elapsed_d) > CmpWidth'(long_press_q)) begin
        ev_d = bdlp_pkg::EvLong;
      end
      if (pending_d) begin
        if (ev_d == bdlp_pkg::EvLongMask) begin
          ev_d = bdlp_pkg::EvRelax;
        end else if (ev_d == bdlp_pkg::EvRelax) begin
          ev_d = bdlp_pkg::EvClickUp;
        end
        pending_d = 1'b0;
      end
      res_d.click_up_event   = (ev_d == bdlp_pkg::EvClickUp);
      res_d.long_press_event = (ev_d == bdlp_pkg::EvLong);
      case (ev_d)
        bdlp_pkg::EvClickUp: ev_d = bdlp_pkg::EvRelax;
        bdlp_pkg::EvLong:    ev_d = bdlp_pkg::EvLongMask;
        default: ;
      endcase
    end
    res_d.status_valid = read_status_i;
    res_d.pressed_now  = pressed_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      pressed_q <= 1'b0;
      pending_q <= 1'b0;
      ev_q      <= bdlp_pkg::EvRelax;
    end else if (in_accept) begin
      elapsed_q <= elapsed_d;
      pressed_q <= pressed_d;
      pending_q <= pending_d;
      ev_q      <= ev_d;
    end
  end

  // output register and skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_take) begin
        out_valid_q  <= skid_valid_q || in_accept;
        skid_valid_q <= 1'b0;
      end else if (in_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end
    if (in_accept && out_valid_q && !out_take) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_valid_o     = out_q.status_valid;
  assign pressed_now_o      = out_q.pressed_now;
  assign long_press_event_o = out_q.long_press_event;
  assign click_up_event_o   = out_q.click_up_event;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_events_need_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.status_valid |-> !out_q.long_press_event && !out_q.click_up_event)
    else $error("event reported without a status read");

  a_events_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.long_press_event && out_q.click_up_event))
    else $error("long press and click-up reported together");

  a_change_clears_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && pressed_d != pressed_q |=> elapsed_q == '0)
    else $error("accepted level change did not clear the timer");

endmodule
